/* hw/rtl/htcs_pkg.sv */
// Package for the hardware thread context scheduler.
// Holds request and event codes, slot flag bits and default sizes.
// No dependencies.
package htcs_pkg;

    localparam int MaxMappedDefault = 8;
    localparam logic [31:0] QuantumReset = 32'd100000;

    localparam logic [1:0] REQ_MAP   = 2'd0;
    localparam logic [1:0] REQ_STAT  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_DRAIN = 2'd3;

    localparam logic [3:0] EV_DONE     = 4'd0;
    localparam logic [3:0] EV_SIGNAL   = 4'd1;
    localparam logic [3:0] EV_EVICTED  = 4'd2;
    localparam logic [3:0] EV_UNMAP    = 4'd3;
    localparam logic [3:0] EV_FREED    = 4'd4;
    localparam logic [3:0] EV_ALLOC    = 4'd5;
    localparam logic [3:0] EV_RENEW    = 4'd6;
    localparam logic [3:0] EV_FULL     = 4'd7;
    localparam logic [3:0] EV_UNKNOWN  = 4'd8;

    localparam int FlagRun = 0;
    localparam int FlagFin = 1;
    localparam int FlagAff = 2;

    typedef struct packed {
        logic [7:0]  ctx;
        logic [7:0]  prio;
        logic [2:0]  flags;
        logic [31:0] evicted_at;
    } slot_entry_t;

endpackage

/* hw/rtl/hw_thread_context_scheduler_core.sv */
// Top level of the hardware thread context scheduler.
// Busy covers a search of the mapped contexts for a map or status item, at most a read
// and write of the current slot for a drain, and the peer, unmap and compaction, and
// allocation passes through the slot memory for a tick; the final beat comes as busy falls.
// Each result beat is shown for one cycle, and the receiver cannot stall.
// Reset is asynchronous: the table empties, quantum returns to 100000.
module hw_thread_context_scheduler_core #(
    parameter int MaxMapped = htcs_pkg::MaxMappedDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  ctx_id,
    input  logic [7:0]  priority_req,
    input  logic        is_running,
    input  logic        is_finished,
    input  logic        has_affinity,
    input  logic [31:0] now_cycle,
    input  logic        pipe_empty,
    output logic        result_valid,
    output logic [3:0]  event_kind,
    output logic [7:0]  event_ctx,
    output logic        last_event
);

    localparam int AW = (MaxMapped > 1) ? $clog2(MaxMapped) : 1;
    localparam int CW = $clog2(MaxMapped + 1);
    localparam logic [CW-1:0] CntMax = CW'(MaxMapped);

    typedef enum logic [4:0] {
        S_IDLE, S_FIND_RD, S_FIND_CHK, S_MAP_WR, S_TK_CUR_RD, S_TK_CUR,
        S_TK_PEER_RD, S_TK_PEER, S_TK_DEC, S_TK_FIN_RD, S_TK_FIN,
        S_UN_RD, S_UN_CHK, S_SH_RD, S_SH_WR, S_AL_RD, S_AL_CHK, S_AL_DONE,
        S_EMIT_DONE, S_DR_RD, S_DR_WR
    } state_t;

    state_t             state_reg;
    logic [31:0]        quantum_reg;
    logic [CW-1:0]      count_reg;
    logic               has_cur_reg;
    logic [AW-1:0]      cur_reg;
    logic [31:0]        alloc_start_reg;
    logic               pend_reg;
    logic [1:0]         req_reg;
    logic [7:0]         id_reg;
    logic [7:0]         prio_reg;
    logic [2:0]         fl_reg;
    logic [31:0]        now_reg;
    logic               pipe_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      wr_reg;
    htcs_pkg::slot_entry_t cur_ent_reg;
    logic               peer_ge_reg;
    logic               peer_gt_reg;
    logic               sel_ok_reg;
    logic [AW-1:0]      sel_reg;
    htcs_pkg::slot_entry_t sel_ent_reg;
    logic               rv_reg;
    logic [3:0]         kind_reg;
    logic [7:0]         ectx_reg;
    logic               last_reg;
    logic               hold_vld_reg;
    logic [3:0]         hold_kind_reg;
    logic [7:0]         hold_ctx_reg;

    logic                  we;
    logic [AW-1:0]         waddr;
    htcs_pkg::slot_entry_t wdata;
    logic [AW-1:0]         raddr;
    htcs_pkg::slot_entry_t rdata;

    htcs_slot_ram #(.Depth(MaxMapped), .AddrW(AW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [AW-1:0] idx_a;
    logic [AW-1:0] wr_a;
    logic          idx_is_cur;
    logic          cur_is_valid;
    logic          expired;
    assign idx_a = idx_reg[AW-1:0];
    assign wr_a  = wr_reg[AW-1:0];
    assign idx_is_cur = has_cur_reg && (CW'(cur_reg) == idx_reg);
    assign cur_is_valid = has_cur_reg && (CW'(cur_reg) < count_reg);
    assign expired = (now_reg - alloc_start_reg) >= quantum_reg;

    always_comb
    begin
        we = 1'b0;
        waddr = idx_a;
        wdata = rdata;
        raddr = idx_a;
        case (state_reg)
            S_MAP_WR:
            begin
                we = 1'b1;
                wdata.ctx = id_reg;
                wdata.prio = prio_reg;
                wdata.flags = fl_reg;
                if (idx_reg < count_reg)
                begin
                    waddr = idx_a;
                    wdata.evicted_at = rdata.evicted_at;
                end
                else
                begin
                    waddr = count_reg[AW-1:0];
                    wdata.evicted_at = '0;
                end
            end
            S_TK_CUR_RD, S_TK_FIN_RD, S_DR_RD: raddr = cur_reg;
            S_TK_FIN, S_DR_WR:
            begin
                we = 1'b1;
                waddr = cur_reg;
                wdata.evicted_at = now_reg;
            end
            S_SH_WR:
            begin
                we = 1'b1;
                waddr = wr_a;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            quantum_reg <= htcs_pkg::QuantumReset;
            count_reg <= '0;
            has_cur_reg <= 1'b0;
            cur_reg <= '0;
            alloc_start_reg <= '0;
            pend_reg <= 1'b0;
            rv_reg <= 1'b0;
            kind_reg <= '0;
            ectx_reg <= '0;
            last_reg <= 1'b0;
            hold_vld_reg <= 1'b0;
            hold_kind_reg <= '0;
            hold_ctx_reg <= '0;
            req_reg <= '0;
            id_reg <= '0;
            prio_reg <= '0;
            fl_reg <= '0;
            now_reg <= '0;
            pipe_reg <= 1'b0;
            idx_reg <= '0;
            wr_reg <= '0;
            cur_ent_reg <= '0;
            peer_ge_reg <= 1'b0;
            peer_gt_reg <= 1'b0;
            sel_ok_reg <= 1'b0;
            sel_reg <= '0;
            sel_ent_reg <= '0;
        end
        else
        begin
            rv_reg <= 1'b0;
            last_reg <= 1'b0;
            if (cfg_we)
            begin
                quantum_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg <= req_type;
                        id_reg <= ctx_id;
                        prio_reg <= priority_req;
                        fl_reg <= {has_affinity, is_finished, is_running};
                        now_reg <= now_cycle;
                        pipe_reg <= pipe_empty;
                        idx_reg <= '0;
                        wr_reg <= '0;
                        case (req_type)
                            htcs_pkg::REQ_MAP, htcs_pkg::REQ_STAT:
                                state_reg <= S_FIND_RD;
                            htcs_pkg::REQ_TICK:
                            begin
                                if (cur_is_valid && !pend_reg)
                                begin
                                    state_reg <= S_TK_CUR_RD;
                                end
                                else
                                begin
                                    state_reg <= S_UN_RD;
                                end
                            end
                            default:
                            begin
                                if (pend_reg && has_cur_reg)
                                begin
                                    state_reg <= S_DR_RD;
                                end
                                else
                                begin
                                    pend_reg <= 1'b0;
                                    state_reg <= S_EMIT_DONE;
                                end
                            end
                        endcase
                    end
                end
                S_FIND_RD:
                begin
                    if (idx_reg < count_reg)
                    begin
                        state_reg <= S_FIND_CHK;
                    end
                    else if (req_reg == htcs_pkg::REQ_STAT)
                    begin
                        rv_reg <= 1'b1;
                        kind_reg <= htcs_pkg::EV_UNKNOWN;
                        ectx_reg <= id_reg;
                        last_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (count_reg >= CntMax)
                    begin
                        rv_reg <= 1'b1;
                        kind_reg <= htcs_pkg::EV_FULL;
                        ectx_reg <= id_reg;
                        last_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_MAP_WR;
                    end
                end
                S_FIND_CHK:
                begin
                    if (rdata.ctx == id_reg)
                    begin
                        state_reg <= S_MAP_WR;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_FIND_RD;
                    end
                end
                S_MAP_WR:
                begin
                    if (idx_reg >= count_reg)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    rv_reg <= 1'b1;
                    kind_reg <= htcs_pkg::EV_DONE;
                    ectx_reg <= id_reg;
                    last_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_TK_CUR_RD:
                begin
                    peer_ge_reg <= 1'b0;
                    peer_gt_reg <= 1'b0;
                    state_reg <= S_TK_CUR;
                end
                S_TK_CUR:
                begin
                    cur_ent_reg <= rdata;
                    state_reg <= S_TK_PEER_RD;
                end
                S_TK_PEER_RD:
                begin
                    if (idx_reg < count_reg)
                    begin
                        state_reg <= S_TK_PEER;
                    end
                    else
                    begin
                        state_reg <= S_TK_DEC;
                    end
                end
                S_TK_PEER:
                begin
                    if (!idx_is_cur && rdata.flags[htcs_pkg::FlagRun])
                    begin
                        if (rdata.prio > cur_ent_reg.prio)
                        begin
                            peer_gt_reg <= 1'b1;
                            peer_ge_reg <= 1'b1;
                        end
                        if (rdata.prio == cur_ent_reg.prio)
                        begin
                            peer_ge_reg <= 1'b1;
                        end
                    end
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= S_TK_PEER_RD;
                end
                S_TK_DEC:
                begin
                    idx_reg <= '0;
                    wr_reg <= '0;
                    state_reg <= S_UN_RD;
                    if (!cur_ent_reg.flags[htcs_pkg::FlagRun] ||
                        !cur_ent_reg.flags[htcs_pkg::FlagAff] ||
                        (expired && count_reg != CW'(1) && peer_ge_reg) ||
                        (!expired && peer_gt_reg))
                    begin
                        pend_reg <= 1'b1;
                        hold_vld_reg <= 1'b1;
                        hold_kind_reg <= htcs_pkg::EV_SIGNAL;
                        hold_ctx_reg <= cur_ent_reg.ctx;
                        if (pipe_reg)
                        begin
                            state_reg <= S_TK_FIN_RD;
                        end
                    end
                    else if (expired)
                    begin
                        alloc_start_reg <= now_reg;
                        hold_vld_reg <= 1'b1;
                        hold_kind_reg <= htcs_pkg::EV_RENEW;
                        hold_ctx_reg <= cur_ent_reg.ctx;
                        if (count_reg == CW'(1))
                        begin
                            state_reg <= S_EMIT_DONE;
                        end
                    end
                end
                S_TK_FIN_RD: state_reg <= S_TK_FIN;
                S_TK_FIN:
                begin
                    rv_reg <= hold_vld_reg;
                    kind_reg <= hold_kind_reg;
                    ectx_reg <= hold_ctx_reg;
                    hold_vld_reg <= 1'b1;
                    hold_kind_reg <= htcs_pkg::EV_EVICTED;
                    hold_ctx_reg <= rdata.ctx;
                    has_cur_reg <= 1'b0;
                    pend_reg <= 1'b0;
                    state_reg <= S_UN_RD;
                end
                S_UN_RD:
                begin
                    if (idx_reg < count_reg)
                    begin
                        state_reg <= S_UN_CHK;
                    end
                    else
                    begin
                        count_reg <= wr_reg;
                        idx_reg <= '0;
                        sel_ok_reg <= 1'b0;
                        if (has_cur_reg)
                        begin
                            state_reg <= S_EMIT_DONE;
                        end
                        else
                        begin
                            state_reg <= S_AL_RD;
                        end
                    end
                end
                S_UN_CHK:
                begin
                    if (!idx_is_cur && (!rdata.flags[htcs_pkg::FlagAff] ||
                                        rdata.flags[htcs_pkg::FlagFin]))
                    begin
                        rv_reg <= hold_vld_reg;
                        kind_reg <= hold_kind_reg;
                        ectx_reg <= hold_ctx_reg;
                        hold_vld_reg <= 1'b1;
                        hold_kind_reg <= rdata.flags[htcs_pkg::FlagFin] ?
                                         htcs_pkg::EV_FREED : htcs_pkg::EV_UNMAP;
                        hold_ctx_reg <= rdata.ctx;
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_UN_RD;
                    end
                    else
                    begin
                        if (idx_is_cur)
                        begin
                            cur_reg <= wr_a;
                        end
                        state_reg <= S_SH_WR;
                    end
                end
                S_SH_WR:
                begin
                    wr_reg <= wr_reg + 1'b1;
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= S_UN_RD;
                end
                S_AL_RD:
                begin
                    if (idx_reg < count_reg)
                    begin
                        state_reg <= S_AL_CHK;
                    end
                    else
                    begin
                        state_reg <= S_AL_DONE;
                    end
                end
                S_AL_CHK:
                begin
                    if (rdata.flags[htcs_pkg::FlagAff] &&
                        rdata.flags[htcs_pkg::FlagRun] &&
                        (!sel_ok_reg ||
                         (sel_ent_reg.evicted_at > rdata.evicted_at &&
                          rdata.prio >= sel_ent_reg.prio)))
                    begin
                        sel_ok_reg <= 1'b1;
                        sel_reg <= idx_a;
                        sel_ent_reg <= rdata;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= S_AL_RD;
                end
                S_AL_DONE:
                begin
                    if (sel_ok_reg)
                    begin
                        has_cur_reg <= 1'b1;
                        cur_reg <= sel_reg;
                        alloc_start_reg <= now_reg;
                        pend_reg <= 1'b0;
                        rv_reg <= hold_vld_reg;
                        kind_reg <= hold_kind_reg;
                        ectx_reg <= hold_ctx_reg;
                        hold_vld_reg <= 1'b1;
                        hold_kind_reg <= htcs_pkg::EV_ALLOC;
                        hold_ctx_reg <= sel_ent_reg.ctx;
                    end
                    state_reg <= S_EMIT_DONE;
                end
                S_EMIT_DONE:
                begin
                    rv_reg <= 1'b1;
                    last_reg <= 1'b1;
                    if (hold_vld_reg)
                    begin
                        kind_reg <= hold_kind_reg;
                        ectx_reg <= hold_ctx_reg;
                    end
                    else
                    begin
                        kind_reg <= htcs_pkg::EV_DONE;
                        ectx_reg <= '0;
                    end
                    hold_vld_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                S_DR_RD: state_reg <= S_DR_WR;
                S_DR_WR:
                begin
                    rv_reg <= 1'b1;
                    kind_reg <= htcs_pkg::EV_EVICTED;
                    ectx_reg <= rdata.ctx;
                    last_reg <= 1'b1;
                    has_cur_reg <= 1'b0;
                    pend_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign event_kind = kind_reg;
    assign event_ctx = ectx_reg;
    assign last_event = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_event |=> !result_valid)
        else $error("beat after final beat of an item");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntMax)
        else $error("slot count exceeds table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !hold_vld_reg)
        else $error("held beat left over at idle");

endmodule

/* hw/rtl/htcs_slot_ram.sv */
// Slot table memory of the thread scheduler: one write port, one read port.
// Read data is registered. Uses htcs_pkg.
module htcs_slot_ram #(
    parameter int Depth = htcs_pkg::MaxMappedDefault,
    parameter int AddrW = $clog2(Depth)
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AddrW-1:0]      waddr,
    input  htcs_pkg::slot_entry_t wdata,
    input  logic [AddrW-1:0]      raddr,
    output htcs_pkg::slot_entry_t rdata
);

    htcs_pkg::slot_entry_t mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* dv/htcs_checker.sv */
`timescale 1ns / 100ps
// Checker for the thread context scheduler: predicts the event beats of each
// accepted request and compares them with the result port. Uses htcs_pkg.
module htcs_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  ctx_id,
    input  logic [7:0]  priority_req,
    input  logic        is_running,
    input  logic        is_finished,
    input  logic        has_affinity,
    input  logic [31:0] now_cycle,
    input  logic        pipe_empty,
    input  logic        result_valid,
    input  logic [3:0]  event_kind,
    input  logic [7:0]  event_ctx,
    input  logic        last_event,
    output int          fail_count,
    output int          pending_events
);
    localparam int Slots = htcs_pkg::MaxMappedDefault;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ctx;
        logic       last;
    } sched_event_t;

    sched_event_t event_q[$];
    logic [31:0] quantum;
    int          mapped;
    htcs_pkg::slot_entry_t table_q[Slots];
    logic        owns;
    int          owner;
    logic [31:0] granted_at;
    logic        evicting;
    int          mismatches;

    assign pending_events = event_q.size();
    assign fail_count = mismatches;

    function automatic void push_event(input logic [3:0] kind, input logic [7:0] ctx);
        sched_event_t e;
        e.kind = kind;
        e.ctx = ctx;
        e.last = 1'b0;
        event_q.push_back(e);
    endfunction

    function automatic logic peer_runs(input logic [7:0] pr, input logic or_equal);
        for (int i = 0; i < mapped; i++)
        begin
            if (i != owner && table_q[i].flags[htcs_pkg::FlagRun]
                && (table_q[i].prio > pr || (or_equal && table_q[i].prio == pr)))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void complete_evict(input logic [31:0] now);
        if (owns)
        begin
            table_q[owner].evicted_at = now;
            push_event(htcs_pkg::EV_EVICTED, table_q[owner].ctx);
        end
        owns = 1'b0;
        evicting = 1'b0;
    endfunction

    function automatic void raise_evict(input logic [31:0] now, input logic drained);
        evicting = 1'b1;
        push_event(htcs_pkg::EV_SIGNAL, table_q[owner].ctx);
        if (drained)
            complete_evict(now);
    endfunction

    function automatic void run_tick(input logic [31:0] now, input logic drained);
        int sel;
        int i;
        logic [2:0] fl;
        logic [7:0] pr;
        if (owns && !evicting)
        begin
            fl = table_q[owner].flags;
            pr = table_q[owner].prio;
            if (!fl[htcs_pkg::FlagRun] || !fl[htcs_pkg::FlagAff])
            begin
                raise_evict(now, drained);
            end
            else if (now - granted_at >= quantum)
            begin
                if (mapped == 1 || !peer_runs(pr, 1'b1))
                begin
                    granted_at = now;
                    push_event(htcs_pkg::EV_RENEW, table_q[owner].ctx);
                    if (mapped == 1)
                        return;
                end
                else
                begin
                    raise_evict(now, drained);
                end
            end
            else if (peer_runs(pr, 1'b0))
            begin
                raise_evict(now, drained);
            end
        end
        i = 0;
        while (i < mapped)
        begin
            fl = table_q[i].flags;
            if (owns && owner == i)
            begin
                i++;
            end
            else if (!fl[htcs_pkg::FlagAff] || fl[htcs_pkg::FlagFin])
            begin
                push_event(fl[htcs_pkg::FlagFin] ? htcs_pkg::EV_FREED : htcs_pkg::EV_UNMAP,
                           table_q[i].ctx);
                for (int j = i; j + 1 < mapped; j++)
                    table_q[j] = table_q[j + 1];
                mapped--;
                if (owns && owner > i)
                    owner--;
            end
            else
            begin
                i++;
            end
        end
        if (!owns)
        begin
            sel = -1;
            for (int k = 0; k < mapped; k++)
            begin
                fl = table_q[k].flags;
                if (fl[htcs_pkg::FlagAff] && fl[htcs_pkg::FlagRun]
                    && (sel < 0 || (table_q[sel].evicted_at > table_q[k].evicted_at
                                    && table_q[k].prio >= table_q[sel].prio)))
                    sel = k;
            end
            if (sel >= 0)
            begin
                owns = 1'b1;
                owner = sel;
                granted_at = now;
                evicting = 1'b0;
                push_event(htcs_pkg::EV_ALLOC, table_q[sel].ctx);
            end
        end
    endfunction

    function automatic void predict_request();
        int first;
        int s;
        logic [2:0] fl;
        first = event_q.size();
        fl = {has_affinity, is_finished, is_running};
        if (req_type == htcs_pkg::REQ_MAP || req_type == htcs_pkg::REQ_STAT)
        begin
            s = -1;
            for (int i = 0; i < mapped; i++)
                if (s < 0 && table_q[i].ctx == ctx_id)
                    s = i;
            if (s >= 0)
            begin
                table_q[s].prio = priority_req;
                table_q[s].flags = fl;
                push_event(htcs_pkg::EV_DONE, ctx_id);
            end
            else if (req_type == htcs_pkg::REQ_STAT)
            begin
                push_event(htcs_pkg::EV_UNKNOWN, ctx_id);
            end
            else if (mapped >= Slots)
            begin
                push_event(htcs_pkg::EV_FULL, ctx_id);
            end
            else
            begin
                table_q[mapped] = '{ctx_id, priority_req, fl, 32'd0};
                mapped++;
                push_event(htcs_pkg::EV_DONE, ctx_id);
            end
        end
        else if (req_type == htcs_pkg::REQ_TICK)
        begin
            run_tick(now_cycle, pipe_empty);
        end
        else if (evicting && owns)
        begin
            complete_evict(now_cycle);
        end
        else
        begin
            evicting = 1'b0;
        end
        if (event_q.size() == first)
            push_event(htcs_pkg::EV_DONE, 8'd0);
        event_q[event_q.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_event_t exp_ev;
        if (!rst_n)
        begin
            quantum <= htcs_pkg::QuantumReset;
            mapped = 0;
            owns = 1'b0;
            owner = 0;
            granted_at = '0;
            evicting = 1'b0;
            mismatches = 0;
            event_q.delete();
        end
        else
        begin
            if (cfg_we)
                quantum <= cfg_wdata;
            if (result_valid)
            begin
                if (event_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected event beat: kind %0d ctx %0d last %0d",
                                 event_kind, event_ctx, last_event);
                end
                else
                begin
                    exp_ev = event_q.pop_front();
                    if (exp_ev.kind !== event_kind || exp_ev.ctx !== event_ctx
                        || exp_ev.last !== last_event)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Event mismatch: expected kind %0d ctx %0d last %0d, %s",
                                     exp_ev.kind, exp_ev.ctx, exp_ev.last,
                                     $sformatf("got kind %0d ctx %0d last %0d",
                                               event_kind, event_ctx, last_event));
                    end
                end
            end
            if (start && !busy)
                predict_request();
        end
    end
endmodule

/* dv/hw_thread_context_scheduler_core_test.sv */
`timescale 1ns / 100ps
// Testbench top for the thread context scheduler: drives requests, quantum
// writes and idle gaps, and reports the verdict. Uses htcs_pkg, htcs_checker and hw_thread_context_scheduler_core.
module hw_thread_context_scheduler_core_test;

    localparam int WatchdogLimit = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  req_type = htcs_pkg::REQ_MAP;
    logic [7:0]  ctx_id = '0;
    logic [7:0]  priority_req = '0;
    logic        is_running = 1'b0;
    logic        is_finished = 1'b0;
    logic        has_affinity = 1'b0;
    logic [31:0] now_cycle = '0;
    logic        pipe_empty = 1'b0;
    logic        result_valid;
    logic [3:0]  event_kind;
    logic [7:0]  event_ctx;
    logic        last_event;
    int          fail_count;
    int          pending_events;
    int          idle_pct;
    int          quiet_cycles;
    logic [31:0] clock_now;

    always #5 clk = ~clk;

    hw_thread_context_scheduler_core u_top (.*);
    htcs_checker u_checker (.*);

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] req, input logic [7:0] id,
                                input logic [7:0] pr, input logic [2:0] fl,
                                input logic [31:0] now, input logic drained);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req_type <= req;
        ctx_id <= id;
        priority_req <= pr;
        {has_affinity, is_finished, is_running} <= fl;
        now_cycle <= now;
        pipe_empty <= drained;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_quantum(input logic [31:0] value);
        start <= 1'b0;
        while (pending_events != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_request();
        logic [1:0]  req;
        logic [7:0]  id;
        logic [2:0]  fl;
        req = 2'($urandom_range(3));
        id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(11));
        fl = ($urandom_range(2) == 0) ? 3'($urandom) : 3'b101;
        clock_now = clock_now + $urandom_range(40);
        if ($urandom_range(19) == 0)
            clock_now = $urandom;
        send_request(req, id, 8'($urandom_range(3) == 0 ? $urandom : $urandom_range(3)),
                     fl, clock_now, 1'($urandom));
    endtask

    initial
    begin
        logic [31:0] quanta[5];
        quanta = '{32'd1, 32'd20, 32'hFFFF_FFFF, 32'd60, 32'd0};
        idle_pct = 0;
        clock_now = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_request(htcs_pkg::REQ_DRAIN, 8'd0, 8'd0, 3'b000, 32'd0, 1'b0);
        send_request(htcs_pkg::REQ_STAT, 8'd9, 8'd1, 3'b101, 32'd0, 1'b0);
        send_request(htcs_pkg::REQ_TICK, 8'd0, 8'd0, 3'b000, 32'd5, 1'b1);
        send_request(htcs_pkg::REQ_MAP, 8'd255, 8'd255, 3'b101, 32'd0, 1'b0);
        send_request(htcs_pkg::REQ_TICK, 8'd0, 8'd0, 3'b000, 32'd10, 1'b0);
        send_request(htcs_pkg::REQ_TICK, 8'd0, 8'd0, 3'b000, 32'd200000, 1'b0);
        for (int i = 0; i < 8; i++)
            send_request(htcs_pkg::REQ_MAP, 8'(i), 8'(i == 0 ? 255 : i), 3'b101,
                         32'd0, 1'b0);
        send_request(htcs_pkg::REQ_MAP, 8'd0, 8'd255, 3'b111, 32'd0, 1'b0);
        send_request(htcs_pkg::REQ_MAP, 8'd200, 8'd0, 3'b000, 32'd0, 1'b0);
        send_request(htcs_pkg::REQ_STAT, 8'd255, 8'd0, 3'b100, 32'd0, 1'b0);
        send_request(htcs_pkg::REQ_TICK, 8'd0, 8'd0, 3'b000, 32'hFFFF_FFF0, 1'b0);
        send_request(htcs_pkg::REQ_TICK, 8'd0, 8'd0, 3'b000, 32'h0000_0010, 1'b1);
        send_request(htcs_pkg::REQ_DRAIN, 8'd0, 8'd0, 3'b000, 32'd20, 1'b1);
        send_request(htcs_pkg::REQ_STAT, 8'd3, 8'd9, 3'b011, 32'd0, 1'b0);
        send_request(htcs_pkg::REQ_TICK, 8'd0, 8'd0, 3'b000, 32'h8000_0000, 1'b0);
        clock_now = 32'h8000_0000;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_quantum(quanta[phase]);
            idle_pct = (phase % 2 == 0) ? 0 : ((phase == 1) ? 58 : 29);
            for (int n = 0; n < 100; n++)
                random_request();
        end
        start <= 1'b0;
        while (pending_events != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
